[sv/sfb_pkg.sv]
`timescale 1ns / 1ps

package sfb_pkg;

  localparam logic [7:0] FLAG_BYTE    = 8'h7E;
  localparam logic [7:0] ESC_BYTE     = 8'h7D;
  localparam logic [7:0] ESC_FLAG     = 8'h5E;
  localparam logic [7:0] ESC_ESC      = 8'h5D;
  localparam logic [7:0] ADDRESS_INIT = 8'h03;
  localparam logic [7:0] CONTROL_INIT = 8'h03;

  // Register indexes on the configuration port.
  localparam logic CFG_ADDRESS = 1'b0;
  localparam logic CFG_CONTROL = 1'b1;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       frame_end;
  } out_item_t;

  // Position inside the byte sequence caused by one input item.
  typedef enum logic [2:0] {
    SLOT_OPEN,
    SLOT_ADDR,
    SLOT_CTRL,
    SLOT_HCS,
    SLOT_DATA,
    SLOT_CHECK,
    SLOT_CLOSE
  } slot_t;

endpackage

[sv/stuffed_frame_builder.sv]
`timescale 1ns / 1ps
// An item's first byte goes out via the work register and then the output register.
// Throughput: one output byte per cycle while the output is not stalled, set by the
// single byte emitter; an item causes 1 to 12 bytes, so a mid-frame unstuffed byte
// sustains one item per cycle and a stuffed one needs an escape byte before its code.
// Reset (synchronous, active high) closes any open frame, clears the payload check,
// empties the output register and sets address and control to 0x03.
module stuffed_frame_builder (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic                    cfg_index,
  input  logic [7:0]              cfg_data,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  sfb_pkg::in_item_t       in_item,
  output logic                    out_valid,
  input  logic                    out_ready,
  output sfb_pkg::out_item_t      out_item
);

  logic [7:0] address_byte;
  logic [7:0] control_byte;
  logic       in_frame;
  logic [7:0] payload_check;

  // Work register: one item being turned into bytes.
  logic          busy;
  sfb_pkg::slot_t slot;
  sfb_pkg::slot_t slot_next;
  logic          esc_pending;
  logic [7:0]    work_addr;
  logic [7:0]    work_ctrl;
  logic [7:0]    work_data;
  logic [7:0]    work_check;
  logic          work_last;

  logic       emit;
  logic       in_fire;
  logic [7:0] raw_byte;
  logic       stuff_slot;
  logic [7:0] emit_byte;
  logic       slot_done;
  logic       item_done;
  logic [7:0] check_next;

  assign emit     = busy && (!out_valid || out_ready);
  assign in_ready = !busy || (emit && item_done);
  assign in_fire  = in_valid && in_ready;
  assign check_next = (in_frame ? payload_check : 8'h00) ^ in_item.payload_byte;

  // Output side of the sequencer.
  always_comb begin
    raw_byte   = sfb_pkg::FLAG_BYTE;
    stuff_slot = 1'b1;
    unique case (slot)
      sfb_pkg::SLOT_OPEN: begin
        raw_byte   = sfb_pkg::FLAG_BYTE;
        stuff_slot = 1'b0;
      end
      sfb_pkg::SLOT_ADDR:  raw_byte = work_addr;
      sfb_pkg::SLOT_CTRL:  raw_byte = work_ctrl;
      sfb_pkg::SLOT_HCS:   raw_byte = work_addr ^ work_ctrl;
      sfb_pkg::SLOT_DATA:  raw_byte = work_data;
      sfb_pkg::SLOT_CHECK: raw_byte = work_check;
      sfb_pkg::SLOT_CLOSE: begin
        raw_byte   = sfb_pkg::FLAG_BYTE;
        stuff_slot = 1'b0;
      end
      default: begin
        raw_byte   = sfb_pkg::FLAG_BYTE;
        stuff_slot = 1'b0;
      end
    endcase

    if (esc_pending) begin
      emit_byte = (raw_byte == sfb_pkg::FLAG_BYTE) ? sfb_pkg::ESC_FLAG : sfb_pkg::ESC_ESC;
      slot_done = 1'b1;
    end else if (stuff_slot &&
                 (raw_byte == sfb_pkg::FLAG_BYTE || raw_byte == sfb_pkg::ESC_BYTE)) begin
      emit_byte = sfb_pkg::ESC_BYTE;
      slot_done = 1'b0;
    end else begin
      emit_byte = raw_byte;
      slot_done = 1'b1;
    end

    item_done = slot_done &&
                ((slot == sfb_pkg::SLOT_DATA && !work_last) || slot == sfb_pkg::SLOT_CLOSE);
  end

  // Next-slot side of the sequencer.
  always_comb begin
    unique case (slot)
      sfb_pkg::SLOT_OPEN:  slot_next = sfb_pkg::SLOT_ADDR;
      sfb_pkg::SLOT_ADDR:  slot_next = sfb_pkg::SLOT_CTRL;
      sfb_pkg::SLOT_CTRL:  slot_next = sfb_pkg::SLOT_HCS;
      sfb_pkg::SLOT_HCS:   slot_next = sfb_pkg::SLOT_DATA;
      sfb_pkg::SLOT_DATA:  slot_next = sfb_pkg::SLOT_CHECK;
      sfb_pkg::SLOT_CHECK: slot_next = sfb_pkg::SLOT_CLOSE;
      sfb_pkg::SLOT_CLOSE: slot_next = sfb_pkg::SLOT_OPEN;
      default:             slot_next = sfb_pkg::SLOT_OPEN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      address_byte <= sfb_pkg::ADDRESS_INIT;
      control_byte <= sfb_pkg::CONTROL_INIT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sfb_pkg::CFG_ADDRESS: address_byte <= cfg_data;
        sfb_pkg::CFG_CONTROL: control_byte <= cfg_data;
        default: ;
      endcase
    end
  end

  // Frame state advances as each item is taken in.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame      <= 1'b0;
      payload_check <= 8'h00;
    end else if (in_fire) begin
      in_frame      <= !in_item.last_byte;
      payload_check <= in_item.last_byte ? 8'h00 : check_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy        <= 1'b0;
      slot        <= sfb_pkg::SLOT_OPEN;
      esc_pending <= 1'b0;
    end else if (in_fire) begin
      busy        <= 1'b1;
      slot        <= in_frame ? sfb_pkg::SLOT_DATA : sfb_pkg::SLOT_OPEN;
      esc_pending <= 1'b0;
    end else if (emit) begin
      if (!slot_done) begin
        esc_pending <= 1'b1;
      end else begin
        esc_pending <= 1'b0;
        slot        <= slot_next;
        if (item_done) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      work_data  <= in_item.payload_byte;
      work_last  <= in_item.last_byte;
      work_check <= check_next;
      if (!in_frame) begin
        work_addr <= address_byte;
        work_ctrl <= control_byte;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_item.out_byte  <= emit_byte;
      out_item.run_last  <= item_done;
      out_item.frame_end <= (slot == sfb_pkg::SLOT_CLOSE);
    end
  end

`ifndef SYNTH
  a_fire_loads_work: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> busy)
    else $error("accepted item did not load the work register");

  a_end_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.frame_end |-> out_item.run_last && out_item.out_byte == sfb_pkg::FLAG_BYTE)
    else $error("closing flag not marked as last byte of its run");

  a_check_clear_idle: assert property (@(posedge clk) disable iff (rst)
    !in_frame |-> payload_check == 8'h00)
    else $error("payload check not cleared outside a frame");

  a_esc_only_busy: assert property (@(posedge clk) disable iff (rst)
    esc_pending |-> busy && slot != sfb_pkg::SLOT_OPEN && slot != sfb_pkg::SLOT_CLOSE)
    else $error("escape pending on a flag slot or while idle");

  a_esc_follows: assert property (@(posedge clk) disable iff (rst)
    $rose(esc_pending) |-> out_valid && out_item.out_byte == sfb_pkg::ESC_BYTE)
    else $error("escape state entered without an escape byte out");
`endif

endmodule
